@@ src/tbrl_pkg.sv @@
package tbrl_pkg;

   localparam int TimeWidth  = 48;
   localparam int WordWidth  = 32;
   localparam int IndexWidth = 2;
   localparam int DivSteps   = TimeWidth;
   localparam int MulSteps   = TimeWidth / 2;
   localparam int StepWidth  = $clog2(DivSteps);
   localparam int AccWidth   = WordWidth + 3;
   localparam int ReqWidth   = 80;
   localparam int RspWidth   = 40;

   localparam logic [IndexWidth-1:0] RegCapacity       = 2'd0;
   localparam logic [IndexWidth-1:0] RegRefillAmount   = 2'd1;
   localparam logic [IndexWidth-1:0] RegRefillInterval = 2'd2;

   typedef struct packed {
      logic load;
      logic div_step;
      logic mul_step;
      logic refill;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic refused;
      logic run_div;
   } dp_status_type;

endpackage

@@ src/tbrl_ctrl.sv @@
module tbrl_ctrl
   import tbrl_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      IDLE,
      CHECK,
      DIVIDE,
      MULTIPLY,
      REFILL,
      FINISH
   } state_type;

   state_type            state_ff;
   logic [StepWidth-1:0] step_ff;
   logic                 rsp_valid_ff;
   logic                 slot_free;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      cmd.load     = (state_ff == IDLE) && req_tvalid;
      cmd.div_step = (state_ff == DIVIDE);
      cmd.mul_step = (state_ff == MULTIPLY);
      cmd.refill   = (state_ff == REFILL);
      cmd.finish   = (state_ff == FINISH) && slot_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_tready && !cmd.finish) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            IDLE: begin
               if (req_tvalid) begin
                  state_ff <= CHECK;
               end
            end
            CHECK: begin
               step_ff <= '0;
               if (status.refused) begin
                  state_ff <= FINISH;
               end else if (status.run_div) begin
                  state_ff <= DIVIDE;
               end else begin
                  state_ff <= REFILL;
               end
            end
            DIVIDE: begin
               if (step_ff == StepWidth'(DivSteps - 1)) begin
                  step_ff  <= '0;
                  state_ff <= MULTIPLY;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            MULTIPLY: begin
               if (step_ff == StepWidth'(MulSteps - 1)) begin
                  step_ff  <= '0;
                  state_ff <= REFILL;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            REFILL: begin
               state_ff <= FINISH;
            end
            FINISH: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

endmodule

@@ src/tbrl_datapath.sv @@
module tbrl_datapath
   import tbrl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [IndexWidth-1:0] csr_index,
   input  logic [WordWidth-1:0]  csr_wdata,
   input  logic [TimeWidth-1:0]  req_now_time,
   input  logic [WordWidth-1:0]  req_request_count,
   input  dp_cmd_type            cmd,
   output dp_status_type         status,
   output logic                  rsp_granted,
   output logic [WordWidth-1:0]  rsp_tokens_left
);

   logic [WordWidth-1:0] capacity_ff, capacity_in;
   logic [WordWidth-1:0] amount_ff, amount_in;
   logic [WordWidth-1:0] interval_ff, interval_in;
   logic [WordWidth-1:0] level_ff, level_in;
   logic [TimeWidth-1:0] last_ff, last_in;
   logic [TimeWidth-1:0] now_ff, now_in;
   logic [WordWidth-1:0] count_ff, count_in;
   logic [TimeWidth-1:0] dq_ff, dq_in;
   logic [WordWidth-1:0] rem_ff, rem_in;
   logic [AccWidth-1:0]  acc_ff, acc_in;
   logic                 sat_ff, sat_in;
   logic                 granted_ff, granted_in;
   logic [WordWidth-1:0] tokens_ff, tokens_in;

   logic                 disabled;
   logic                 refused;
   logic [WordWidth-1:0] room;
   logic [WordWidth:0]   trial;
   logic [AccWidth-1:0]  next_acc;

   assign disabled = (capacity_ff == '0) || (amount_ff == '0) || (interval_ff == '0);
   assign refused  = (capacity_ff < count_ff);
   assign room     = (capacity_ff > level_ff) ? (capacity_ff - level_ff) : '0;
   assign trial    = {rem_ff, dq_ff[TimeWidth-1]};
   assign next_acc = {acc_ff[AccWidth-3:0], 2'b00}
                   + (dq_ff[TimeWidth-1] ? {2'b00, amount_ff, 1'b0} : '0)
                   + (dq_ff[TimeWidth-2] ? {3'b000, amount_ff} : '0);

   assign status.refused = refused;
   assign status.run_div = !disabled && (now_ff > last_ff);

   assign rsp_granted     = granted_ff;
   assign rsp_tokens_left = tokens_ff;

   always_comb begin
      capacity_in = capacity_ff;
      amount_in   = amount_ff;
      interval_in = interval_ff;
      level_in    = level_ff;
      last_in     = last_ff;
      now_in      = now_ff;
      count_in    = count_ff;
      dq_in       = dq_ff;
      rem_in      = rem_ff;
      acc_in      = acc_ff;
      sat_in      = sat_ff;
      granted_in  = granted_ff;
      tokens_in   = tokens_ff;

      if (csr_we) begin
         case (csr_index)
            RegCapacity: begin
               capacity_in = csr_wdata;
               if (interval_ff == '0 || level_ff > csr_wdata) begin
                  level_in = csr_wdata;
               end
            end
            RegRefillAmount: begin
               amount_in = csr_wdata;
            end
            RegRefillInterval: begin
               interval_in = csr_wdata;
               if (csr_wdata == '0) begin
                  level_in = capacity_ff;
               end
            end
            default: begin
            end
         endcase
      end

      if (cmd.load) begin
         now_in   = req_now_time;
         count_in = req_request_count;
         dq_in    = req_now_time - last_ff;
         rem_in   = '0;
         acc_in   = '0;
         sat_in   = 1'b0;
      end

      if (cmd.div_step) begin
         if (trial >= {1'b0, interval_ff}) begin
            rem_in = WordWidth'(trial - {1'b0, interval_ff});
            dq_in  = {dq_ff[TimeWidth-2:0], 1'b1};
         end else begin
            rem_in = trial[WordWidth-1:0];
            dq_in  = {dq_ff[TimeWidth-2:0], 1'b0};
         end
      end

      if (cmd.mul_step) begin
         dq_in = {dq_ff[TimeWidth-3:0], 2'b00};
         if (!sat_ff) begin
            acc_in = next_acc;
            sat_in = (next_acc > {3'b000, room});
         end
      end

      if (cmd.refill && !disabled) begin
         if (now_ff < last_ff) begin
            last_in = now_ff;
         end else if (now_ff != last_ff) begin
            if (sat_ff) begin
               level_in = (level_ff < capacity_ff) ? capacity_ff : level_ff;
               last_in  = now_ff;
            end else begin
               level_in = level_ff + acc_ff[WordWidth-1:0];
               last_in  = now_ff - {{(TimeWidth-WordWidth){1'b0}}, rem_ff};
            end
         end
      end

      if (cmd.finish) begin
         tokens_in = level_ff;
         if (refused) begin
            granted_in = 1'b0;
         end else if (count_ff == '0 || (interval_ff == '0 && amount_ff != '0)) begin
            granted_in = 1'b1;
         end else if (level_ff < count_ff) begin
            granted_in = 1'b0;
         end else begin
            granted_in = 1'b1;
            level_in   = level_ff - count_ff;
            tokens_in  = level_ff - count_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= '0;
         amount_ff   <= '0;
         interval_ff <= '0;
         level_ff    <= '0;
         last_ff     <= '0;
      end else begin
         capacity_ff <= capacity_in;
         amount_ff   <= amount_in;
         interval_ff <= interval_in;
         level_ff    <= level_in;
         last_ff     <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff     <= now_in;
      count_ff   <= count_in;
      dq_ff      <= dq_in;
      rem_ff     <= rem_in;
      acc_ff     <= acc_in;
      sat_ff     <= sat_in;
      granted_ff <= granted_in;
      tokens_ff  <= tokens_in;
   end

endmodule

@@ src/token_bucket_rate_limiter.sv @@
// Channel    Direction  Ports                        Contents
// request    in         req_tvalid/tready/tdata      now_time, request_count
// response   out        rsp_tvalid/tready/tdata      granted, tokens_left
// csr        in         csr_we/csr_index/csr_wdata   capacity, refill_amount, refill_interval
//
// A request that refills passes from acceptance to a valid response through a check state,
// the restoring divider for the elapsed ticks, the two-bit serial multiplier for the added
// tokens, a refill state and a grant state. A refused request goes from the check state
// straight to the grant state, and one without a refill skips the divider and multiplier.
// One request is in work at a time; a new one is taken once the response register
// is loaded, and its grant state waits while the earlier response still waits.
// Reset is synchronous and clears the control state, the registers and the token state.
module token_bucket_rate_limiter
   import tbrl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [47:0] now_time, [79:48] request_count
   input  logic [ReqWidth-1:0]   req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] granted, [32:1] tokens_left, [39:33] zero
   output logic [RspWidth-1:0]   rsp_tdata,
   input  logic                  csr_we,
   input  logic [IndexWidth-1:0] csr_index,
   input  logic [WordWidth-1:0]  csr_wdata
);

   dp_cmd_type           cmd;
   dp_status_type        status;
   logic                 granted;
   logic [WordWidth-1:0] tokens_left;

   tbrl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tbrl_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_now_time      (req_tdata[TimeWidth-1:0]),
      .req_request_count (req_tdata[TimeWidth+WordWidth-1:TimeWidth]),
      .cmd               (cmd),
      .status            (status),
      .rsp_granted       (granted),
      .rsp_tokens_left   (tokens_left)
   );

   assign rsp_tdata = {{(RspWidth-WordWidth-1){1'b0}}, tokens_left, granted};

endmodule

@@ test/token_bucket_rate_limiter_tb.sv @@
`timescale 1ns / 100ps

module token_bucket_rate_limiter_tb
   import tbrl_pkg::*;
;

   localparam logic [IndexWidth-1:0] RegUnused = 2'd3;
   localparam logic [TimeWidth-1:0] TimeMax = '1;
   localparam logic [WordWidth-1:0] WordMax = '1;
   localparam int LongHold     = 400;
   localparam int StallLimit   = 5000;
   localparam int DrainCycles  = 100;
   localparam int RandomPhases = 12;
   localparam int PhaseItems   = 75;

   typedef struct packed {
      logic [WordWidth-1:0] count;
      logic [TimeWidth-1:0] now_time;
   } request_type;

   typedef struct packed {
      logic [WordWidth-1:0] tokens_left;
      logic                 granted;
   } grant_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [ReqWidth-1:0]   req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RspWidth-1:0]   rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [IndexWidth-1:0] csr_index = '0;
   logic [WordWidth-1:0]  csr_wdata = '0;

   logic [WordWidth-1:0] bucket_cap = '0;
   logic [WordWidth-1:0] bucket_amount = '0;
   logic [WordWidth-1:0] bucket_interval = '0;
   logic [WordWidth-1:0] bucket_level = '0;
   logic [TimeWidth-1:0] bucket_stamp = '0;

   request_type request_q[$];
   grant_type   grant_q[$];

   int unsigned queued_count = 0;
   int unsigned checked_count = 0;
   int unsigned granted_count = 0;
   int unsigned refused_count = 0;
   int unsigned mismatch_count = 0;
   int unsigned writes_done = 0;
   int unsigned idle_pct = 0;
   int unsigned hold_requests = 0;
   int unsigned holds_done = 0;
   int unsigned hold_left = 0;
   int unsigned stall_left = 0;
   int unsigned send_gap = 0;
   int unsigned quiet_cycles = 0;

   token_bucket_rate_limiter i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic grant_type serve_request(request_type r);
      grant_type   g;
      logic [63:0] ticks;
      logic [63:0] room;
      g.granted = 1'b0;
      if (r.count <= bucket_cap) begin
         if (bucket_cap != 0 && bucket_amount != 0 && bucket_interval != 0) begin
            if (r.now_time < bucket_stamp) begin
               bucket_stamp = r.now_time;
            end else if (r.now_time != bucket_stamp) begin
               ticks = 64'(r.now_time - bucket_stamp) / 64'(bucket_interval);
               if (ticks != 0) begin
                  room = (bucket_cap > bucket_level) ? 64'(bucket_cap - bucket_level) : 64'd0;
                  if (64'(bucket_amount) > room / ticks) begin
                     bucket_level = bucket_level + room[WordWidth-1:0];
                     bucket_stamp = r.now_time;
                  end else begin
                     bucket_level = bucket_level + WordWidth'(64'(bucket_amount) * ticks);
                     bucket_stamp = bucket_stamp + TimeWidth'(64'(bucket_interval) * ticks);
                  end
               end
            end
         end
         if (r.count == 0 || (bucket_interval == 0 && bucket_amount != 0)) begin
            g.granted = 1'b1;
         end else if (bucket_level >= r.count) begin
            bucket_level = bucket_level - r.count;
            g.granted = 1'b1;
         end
      end
      g.tokens_left = bucket_level;
      return g;
   endfunction

   function automatic logic [WordWidth-1:0] pick_setting();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return 1;
         2: return WordMax;
         3, 4: return $urandom_range(2, 20);
         5: return $urandom_range(21, 1000);
         default: return $urandom();
      endcase
   endfunction

   task automatic report_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("Mismatch at %0t: %s", $realtime, what);
      end
   endtask

   task automatic write_reg(logic [IndexWidth-1:0] index, logic [WordWidth-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         RegCapacity: begin
            bucket_cap = value;
            if (bucket_interval != 0) begin
               if (bucket_level > value) begin
                  bucket_level = value;
               end
            end else begin
               bucket_level = value;
            end
         end
         RegRefillAmount: begin
            bucket_amount = value;
         end
         RegRefillInterval: begin
            bucket_interval = value;
            if (value == 0) begin
               bucket_level = bucket_cap;
            end
         end
         default: ;
      endcase
      writes_done++;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic queue_request(logic [TimeWidth-1:0] now_time, logic [WordWidth-1:0] count);
      request_q.push_back('{count: count, now_time: now_time});
      queued_count++;
   endtask

   task automatic wait_drained();
      while (checked_count != queued_count) begin
         @(negedge clock);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            grant_q.push_back(serve_request(req_tdata));
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
               send_gap = $urandom_range(0, 9);
               req_tvalid <= 1'b0;
            end else if (request_q.size() != 0) begin
               req_tdata <= request_q.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left = 0;
         stall_left = 0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (holds_done != hold_requests) begin
         holds_done++;
         hold_left = LongHold - 1;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         stall_left = $urandom_range(0, 9);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      grant_type seen;
      grant_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = rsp_tdata[WordWidth:0];
         if (grant_q.size() == 0) begin
            report_mismatch($sformatf("unexpected response granted=%0b tokens_left=%0d",
                                      seen.granted, seen.tokens_left));
         end else begin
            want = grant_q.pop_front();
            checked_count++;
            if (seen.granted) begin
               granted_count++;
            end else begin
               refused_count++;
            end
            if (seen.granted !== want.granted) begin
               report_mismatch($sformatf("response %0d granted: expected %0b, actual %0b",
                                         checked_count, want.granted, seen.granted));
            end
            if (seen.tokens_left !== want.tokens_left) begin
               report_mismatch($sformatf("response %0d tokens_left: expected %0d, actual %0d",
                                         checked_count, want.tokens_left, seen.tokens_left));
            end
            if (rsp_tdata[RspWidth-1:WordWidth+1] !== '0) begin
               report_mismatch($sformatf("response %0d padding: expected 0, actual %h",
                                         checked_count, rsp_tdata[RspWidth-1:WordWidth+1]));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= StallLimit) begin
            $display("Timeout: no transfer for %0d cycles, %0d of %0d responses checked.",
                     StallLimit, checked_count, queued_count);
            $display("** token_bucket_rate_limiter: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      logic [IndexWidth-1:0] order [3];
      logic [TimeWidth-1:0]  now_mark;
      logic [63:0]           delta;
      logic [WordWidth-1:0]  count;
      int                    first;

      order = '{RegCapacity, RegRefillAmount, RegRefillInterval};
      now_mark = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Registers still at their reset values: only zero-token requests pass.
      idle_pct = 30;
      queue_request(0, 0);
      queue_request(TimeMax, 1);
      queue_request(0, WordMax);
      wait_drained();

      write_reg(RegCapacity, 10);
      write_reg(RegRefillAmount, 3);
      write_reg(RegRefillInterval, 5);
      queue_request(100, 4);
      queue_request(106, 0);
      queue_request(104, 9);
      queue_request(104, 11);
      queue_request(107, 1);
      queue_request(200, 10);
      wait_drained();

      // Instant mode, then a zero interval with no refill amount.
      write_reg(RegRefillInterval, 0);
      queue_request(300, 5);
      queue_request(0, 10);
      wait_drained();
      write_reg(RegRefillAmount, 0);
      queue_request(50, 7);
      queue_request(60, 4);
      wait_drained();

      write_reg(RegRefillInterval, WordMax);
      write_reg(RegRefillAmount, WordMax);
      write_reg(RegCapacity, WordMax);
      queue_request(TimeMax, WordMax);
      queue_request(0, 0);
      wait_drained();

      write_reg(RegRefillInterval, 1);
      write_reg(RegRefillAmount, 1);
      queue_request(1000, 0);
      wait_drained();

      // Shrinking the capacity clamps the level; the unused index changes nothing.
      write_reg(RegCapacity, 5);
      write_reg(RegUnused, WordMax);
      queue_request(1000, 5);
      queue_request(TimeMax, WordMax);
      queue_request(TimeMax, 5);
      queue_request(TimeMax, 0);
      wait_drained();

      for (int phase = 0; phase < RandomPhases; phase++) begin
         first = $urandom_range(0, 2);
         for (int k = 0; k < 3; k++) begin
            if (phase == 0 || $urandom_range(0, 3) != 0) begin
               write_reg(order[(first + k) % 3], pick_setting());
            end
         end
         if ($urandom_range(0, 5) == 0) begin
            write_reg(RegUnused, $urandom());
         end

         idle_pct = (phase == RandomPhases - 1) ? 0 : (phase % 3) * 25;
         if (phase == 2) begin
            hold_requests++;
         end

         for (int n = 0; n < PhaseItems; n++) begin
            case ($urandom_range(0, 19))
               0: now_mark = TimeWidth'({$urandom(), $urandom()});
               1: now_mark = now_mark - TimeWidth'($urandom_range(1, 1000));
               2: ;
               default: begin
                  if ($urandom_range(0, 1) != 0) begin
                     delta = 64'(bucket_interval) * $urandom_range(0, 3) + $urandom_range(0, 3);
                  end else begin
                     delta = {$urandom(), $urandom()} % (64'(bucket_interval) * 2 + 64'd2);
                  end
                  now_mark = now_mark + TimeWidth'(delta);
               end
            endcase
            case ($urandom_range(0, 9))
               0: count = '0;
               1: count = $urandom();
               2: count = bucket_cap;
               3: count = bucket_cap + 1;
               4, 5: count = $urandom_range(0, 16);
               default: count = $urandom_range(bucket_cap, 0);
            endcase
            queue_request(now_mark, count);
         end
         wait_drained();
      end

      repeat (DrainCycles) @(posedge clock);
      if (grant_q.size() != 0) begin
         report_mismatch($sformatf("%0d expected responses never arrived", grant_q.size()));
      end

      $display("Checked %0d requests (%0d granted, %0d refused) across %0d settings phases.",
               checked_count, granted_count, refused_count, RandomPhases + 6);
      $display("%0d register writes, idle bursts on both sides and %0d long response hold-off.",
               writes_done, holds_done);
      if (mismatch_count == 0) begin
         $display("** token_bucket_rate_limiter: PASSED **");
      end else begin
         $display("** token_bucket_rate_limiter: FAILED **");
      end
      $finish;
   end

endmodule

@@ files.f @@
src/tbrl_pkg.sv
src/tbrl_ctrl.sv
src/tbrl_datapath.sv
src/token_bucket_rate_limiter.sv
test/token_bucket_rate_limiter_tb.sv
